FILE: rtl/bpm_pkg.sv
// Shared types, constants and mix functions for the bilinear RGBA pixel mix.
// Used by every module of the block; depends on nothing.
`default_nettype none
package bpm_pkg;

  // Fraction format of the mix ratios
  localparam int unsigned FRAC_BITS = 16;
  localparam logic [15:0] FRAC_MASK = 16'((64'd1 << FRAC_BITS) - 64'd1);

  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Pipelined divider: quotient bits resolved per stage and stage count
  localparam int unsigned DIV_STEP   = 2;
  localparam int unsigned DIV_STAGES = 9;
  localparam int unsigned DIV_NUM_W  = DIV_STEP * DIV_STAGES;

  // Queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    CLS_CLEAR  = 2'd0,
    CLS_OPAQUE = 2'd1,
    CLS_BLEND  = 2'd2
  } cls_e;

  // Item handed from the front to the back
  typedef struct packed {
    logic [3:0][31:0] pix;
    logic [15:0]      rx;
    logic [15:0]      ry;
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic [7:0]       fa;
    cls_e             cls;
  } front_item_t;

  // floor((b - a) * r / 2^FRAC_BITS) + a, modulo 256
  function automatic logic [7:0] mix_plain(input logic [7:0] a, input logic [7:0] b,
                                           input logic [15:0] r);
    logic signed [8:0]  d;
    logic signed [25:0] p;
    logic signed [25:0] s;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, r});
    s = p >>> FRAC_BITS;
    return s[7:0] + a;
  endfunction

  // floor(diff * rr / 2^FRAC_BITS) + q, modulo 256
  function automatic logic [7:0] mix_finish(input logic signed [16:0] diff,
                                            input logic [15:0] rr, input logic [15:0] q);
    logic signed [33:0] p;
    logic signed [33:0] s;
    p = diff * $signed({1'b0, rr});
    s = p >>> FRAC_BITS;
    return s[7:0] + q[7:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/bpm_fifo.sv
// Short queue of front items between the front and the back of the pixel mix.
// Depends on bpm_pkg for the item type and depth.
`default_nettype none
module bpm_fifo (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire bpm_pkg::front_item_t item_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      valid_o,
  output bpm_pkg::front_item_t      item_o
);

  localparam int unsigned PtrW = (bpm_pkg::FIFO_DEPTH > 1) ? $clog2(bpm_pkg::FIFO_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(bpm_pkg::FIFO_DEPTH + 1);

  bpm_pkg::front_item_t mem_q [bpm_pkg::FIFO_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(bpm_pkg::FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers with wrap at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(bpm_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(bpm_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bpm_front.sv
// Front of the pixel mix: accepts items, mixes alpha and classifies each item.
// Depends on bpm_pkg for the item type and the plain mix function.
`default_nettype none
module bpm_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [31:0]     pix_self_i,
  input  wire logic [31:0]     pix_right_i,
  input  wire logic [31:0]     pix_below_i,
  input  wire logic [31:0]     pix_below_right_i,
  input  wire logic [15:0]     frac_x_i,
  input  wire logic [15:0]     frac_y_i,
  output logic                 push_o,
  output bpm_pkg::front_item_t item_o,
  input  wire logic            full_i
);

  logic                 en;
  logic                 s1_valid_q, s2_valid_q;
  bpm_pkg::front_item_t s1_q, s1_d, s2_q, s2_d;

  // Advance the whole front unless its last stage waits on a full queue
  assign en         = !s2_valid_q || !full_i;
  assign in_ready_o = en;
  assign push_o     = s2_valid_q && !full_i;
  assign item_o     = s2_q;

  // Stage one: mix alpha along the top and bottom rows
  always_comb begin
    s1_d     = '0;
    s1_d.pix = {pix_below_right_i, pix_below_i, pix_right_i, pix_self_i};
    s1_d.rx  = frac_x_i & bpm_pkg::FRAC_MASK;
    s1_d.ry  = frac_y_i & bpm_pkg::FRAC_MASK;
    s1_d.a0  = bpm_pkg::mix_plain(pix_self_i[31:24], pix_right_i[31:24], s1_d.rx);
    s1_d.a1  = bpm_pkg::mix_plain(pix_below_i[31:24], pix_below_right_i[31:24], s1_d.rx);
    s1_d.cls = bpm_pkg::CLS_CLEAR;
  end

  // Stage two: mix alpha vertically and classify
  always_comb begin
    s2_d    = s1_q;
    s2_d.fa = bpm_pkg::mix_plain(s1_q.a0, s1_q.a1, s1_q.ry);
    if (s2_d.fa == bpm_pkg::ALPHA_CLEAR) begin
      s2_d.cls = bpm_pkg::CLS_CLEAR;
    end else if (s2_d.fa == bpm_pkg::ALPHA_OPAQUE) begin
      s2_d.cls = bpm_pkg::CLS_OPAQUE;
    end else begin
      s2_d.cls = bpm_pkg::CLS_BLEND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bpm_div.sv
// Pipelined ceiling-free divider lane: 17-bit dividend by 8-bit divisor,
// a few quotient bits per stage. Depends on bpm_pkg for the stage layout.
`default_nettype none
module bpm_div (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [16:0] num_i,
  input  wire logic [7:0]  den_i,
  output logic [15:0]      quo_o
);

  localparam int unsigned NumW = bpm_pkg::DIV_NUM_W;
  localparam int unsigned Last = bpm_pkg::DIV_STAGES - 1;

  logic [7:0]      rem_q [bpm_pkg::DIV_STAGES];
  logic [7:0]      rem_d [bpm_pkg::DIV_STAGES];
  logic [7:0]      den_q [bpm_pkg::DIV_STAGES];
  logic [7:0]      den_d [bpm_pkg::DIV_STAGES];
  logic [NumW-1:0] num_q [bpm_pkg::DIV_STAGES];
  logic [NumW-1:0] num_d [bpm_pkg::DIV_STAGES];
  logic [NumW-1:0] quo_q [bpm_pkg::DIV_STAGES];
  logic [NumW-1:0] quo_d [bpm_pkg::DIV_STAGES];

  // Resolve quotient bits, restoring one bit per step
  always_comb begin
    logic [8:0]      t;
    logic [7:0]      r;
    logic [7:0]      d;
    logic [NumW-1:0] n;
    logic [NumW-1:0] q;
    for (int s = 0; s < bpm_pkg::DIV_STAGES; s++) begin
      if (s == 0) begin
        r = '0;
        d = den_i;
        n = NumW'(num_i);
        q = '0;
      end else begin
        r = rem_q[s-1];
        d = den_q[s-1];
        n = num_q[s-1];
        q = quo_q[s-1];
      end
      for (int k = 0; k < bpm_pkg::DIV_STEP; k++) begin
        t = {r, n[NumW-1]};
        n = {n[NumW-2:0], 1'b0};
        if (t >= {1'b0, d}) begin
          r = 8'(t - {1'b0, d});
          q = {q[NumW-2:0], 1'b1};
        end else begin
          r = t[7:0];
          q = {q[NumW-2:0], 1'b0};
        end
      end
      rem_d[s] = r;
      den_d[s] = d;
      num_d[s] = n;
      quo_d[s] = q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      den_q <= den_d;
      num_q <= num_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o = quo_q[Last][15:0];

endmodule
`default_nettype wire

FILE: rtl/bpm_back.sv
// Back of the pixel mix: alpha-weighted colour mixing with two divider passes.
// Depends on bpm_pkg and instantiates bpm_div lanes.
`default_nettype none
module bpm_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 valid_i,
  input  wire bpm_pkg::front_item_t item_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [31:0]               pixel_out_o
);

  localparam int unsigned Last = bpm_pkg::DIV_STAGES - 1;

  typedef struct packed {
    logic [2:0][16:0] dtop;
    logic [2:0][16:0] dbot;
    logic [2:0][7:0]  pt;
    logic [2:0][7:0]  pb;
    logic [7:0]       a0;
    logic [7:0]       a1;
    logic [7:0]       fa;
    logic [15:0]      ry;
    bpm_pkg::cls_e    cls;
    logic             vld;
  } sb1_t;

  typedef struct packed {
    logic [2:0][16:0] dv;
    logic [2:0][7:0]  opq;
    logic [15:0]      rry;
    logic [7:0]       fa;
    bpm_pkg::cls_e    cls;
    logic             vld;
  } sb2_t;

  typedef struct packed {
    logic [2:0][7:0] t;
    logic [2:0][7:0] b;
    logic [2:0][7:0] opq;
    logic [7:0]      a0;
    logic [7:0]      a1;
    logic [7:0]      fa;
    logic [15:0]     rry;
    bpm_pkg::cls_e   cls;
    logic            vld;
  } e2_t;

  logic en;
  logic out_valid_q;
  logic [31:0] pixel_q, pixel_d;

  sb1_t        e1_q, e1_d;
  logic [16:0] num1_q [9];
  logic [16:0] num1_d [9];
  logic [7:0]  den1_q [9];
  logic [7:0]  den1_d [9];
  logic [15:0] quo1 [9];
  sb1_t        sb1_q [bpm_pkg::DIV_STAGES];

  e2_t         e2_q, e2_d;
  sb2_t        e3_q, e3_d;
  logic [16:0] num2_q [3];
  logic [16:0] num2_d [3];
  logic [15:0] quo2 [3];
  sb2_t        sb2_q [bpm_pkg::DIV_STAGES];

  // Advance the whole back unless the output register is held
  assign en          = !out_valid_q || out_ready_i;
  assign pop_o       = en && valid_i;
  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_q;

  // Stage E1: alpha products, plain row mixes and dividends of the first pass
  always_comb begin
    logic [15:0] ftop, fbtop, fbot, fbbot;
    e1_d     = '0;
    e1_d.a0  = item_i.a0;
    e1_d.a1  = item_i.a1;
    e1_d.fa  = item_i.fa;
    e1_d.ry  = item_i.ry;
    e1_d.cls = item_i.cls;
    e1_d.vld = valid_i;
    num1_d[0] = {1'b0, item_i.rx} + 17'(item_i.a0) - 17'd1;
    den1_d[0] = item_i.a0;
    num1_d[1] = {1'b0, item_i.rx} + 17'(item_i.a1) - 17'd1;
    den1_d[1] = item_i.a1;
    num1_d[2] = {1'b0, item_i.ry} + 17'(item_i.fa) - 17'd1;
    den1_d[2] = item_i.fa;
    for (int c = 0; c < 3; c++) begin
      ftop  = item_i.pix[0][c*8 +: 8] * item_i.pix[0][31:24];
      fbtop = item_i.pix[1][c*8 +: 8] * item_i.pix[1][31:24];
      fbot  = item_i.pix[2][c*8 +: 8] * item_i.pix[2][31:24];
      fbbot = item_i.pix[3][c*8 +: 8] * item_i.pix[3][31:24];
      e1_d.dtop[c] = {1'b0, fbtop} - {1'b0, ftop};
      e1_d.dbot[c] = {1'b0, fbbot} - {1'b0, fbot};
      e1_d.pt[c]   = bpm_pkg::mix_plain(item_i.pix[0][c*8 +: 8], item_i.pix[1][c*8 +: 8],
                                        item_i.rx);
      e1_d.pb[c]   = bpm_pkg::mix_plain(item_i.pix[2][c*8 +: 8], item_i.pix[3][c*8 +: 8],
                                        item_i.rx);
      num1_d[3+c]  = {1'b0, ftop} + 17'(item_i.a0) - 17'd1;
      den1_d[3+c]  = item_i.a0;
      num1_d[6+c]  = {1'b0, fbot} + 17'(item_i.a1) - 17'd1;
      den1_d[6+c]  = item_i.a1;
    end
  end

  // First divider pass: row ratios, column ratio and row base terms
  for (genvar g = 0; g < 9; g++) begin : g_div1
    bpm_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num1_q[g]),
      .den_i (den1_q[g]),
      .quo_o (quo1[g])
    );
  end

  // Stage E2: finish row mixes, choosing by row alpha
  always_comb begin
    logic [7:0] wt, wb;
    sb1_t       s;
    s        = sb1_q[Last];
    e2_d     = '0;
    e2_d.a0  = s.a0;
    e2_d.a1  = s.a1;
    e2_d.fa  = s.fa;
    e2_d.rry = quo1[2];
    e2_d.cls = s.cls;
    e2_d.vld = s.vld;
    for (int c = 0; c < 3; c++) begin
      wt = bpm_pkg::mix_finish($signed(s.dtop[c]), quo1[0], quo1[3+c]);
      wb = bpm_pkg::mix_finish($signed(s.dbot[c]), quo1[1], quo1[6+c]);
      if (s.a0 == bpm_pkg::ALPHA_CLEAR) begin
        e2_d.t[c] = '0;
      end else if (s.a0 == bpm_pkg::ALPHA_OPAQUE) begin
        e2_d.t[c] = s.pt[c];
      end else begin
        e2_d.t[c] = wt;
      end
      if (s.a1 == bpm_pkg::ALPHA_CLEAR) begin
        e2_d.b[c] = '0;
      end else if (s.a1 == bpm_pkg::ALPHA_OPAQUE) begin
        e2_d.b[c] = s.pb[c];
      end else begin
        e2_d.b[c] = wb;
      end
      e2_d.opq[c] = bpm_pkg::mix_plain(s.pt[c], s.pb[c], s.ry);
    end
  end

  // Stage E3: weight row results by row alpha for the column mix
  always_comb begin
    logic [15:0] pt, pb;
    e3_d     = '0;
    e3_d.opq = e2_q.opq;
    e3_d.rry = e2_q.rry;
    e3_d.fa  = e2_q.fa;
    e3_d.cls = e2_q.cls;
    e3_d.vld = e2_q.vld;
    for (int c = 0; c < 3; c++) begin
      pt = e2_q.t[c] * e2_q.a0;
      pb = e2_q.b[c] * e2_q.a1;
      e3_d.dv[c] = {1'b0, pb} - {1'b0, pt};
      num2_d[c]  = {1'b0, pt} + 17'(e2_q.fa) - 17'd1;
    end
  end

  // Second divider pass: column base terms
  for (genvar g = 0; g < 3; g++) begin : g_div2
    bpm_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num2_q[g]),
      .den_i (e3_q.fa),
      .quo_o (quo2[g])
    );
  end

  // Output stage: finish the column mix and pick by class
  always_comb begin
    sb2_t s;
    s = sb2_q[Last];
    case (s.cls)
      bpm_pkg::CLS_OPAQUE: begin
        pixel_d = {bpm_pkg::ALPHA_OPAQUE, s.opq[2], s.opq[1], s.opq[0]};
      end
      bpm_pkg::CLS_BLEND: begin
        pixel_d = {s.fa,
                   bpm_pkg::mix_finish($signed(s.dv[2]), s.rry, quo2[2]),
                   bpm_pkg::mix_finish($signed(s.dv[1]), s.rry, quo2[1]),
                   bpm_pkg::mix_finish($signed(s.dv[0]), s.rry, quo2[0])};
      end
      default: begin
        pixel_d = '0;
      end
    endcase
  end

  // Stage registers and delay lines beside the dividers, valid flags cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_q        <= '0;
      e2_q        <= '0;
      e3_q        <= '0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < bpm_pkg::DIV_STAGES; s++) begin
        sb1_q[s] <= '0;
        sb2_q[s] <= '0;
      end
    end else if (en) begin
      e1_q        <= e1_d;
      e2_q        <= e2_d;
      e3_q        <= e3_d;
      out_valid_q <= sb2_q[Last].vld;
      sb1_q[0]    <= e1_q;
      sb2_q[0]    <= e3_q;
      for (int s = 1; s < bpm_pkg::DIV_STAGES; s++) begin
        sb1_q[s] <= sb1_q[s-1];
        sb2_q[s] <= sb2_q[s-1];
      end
    end
  end

  // Payload: divider operands and the output pixel
  always_ff @(posedge clk_i) begin
    if (en) begin
      num1_q  <= num1_d;
      den1_q  <= den1_d;
      num2_q  <= num2_d;
      pixel_q <= pixel_d;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bilinear_rgba_pixel_mix.sv
// Top level of the bilinear RGBA pixel mix: front, queue and back.
// Depends on bpm_pkg, bpm_front, bpm_fifo, bpm_back.
//
// Usage: one input item carries four neighboring RGBA8888 pixels (self,
// right, below, below-right; byte 3 is alpha) and two 0.16 mix fractions.
// One result item, the interpolated pixel, comes out for each input item,
// in order. Both channels use valid/ready; an item moves when both are high.
// Throughput: one item per clock while the receiver keeps out_ready_i high.
// Path from acceptance to output valid: two front stages (alpha mix and
// classification), the queue, then the back pipeline whose length is
// set by two passes through the 9-stage divider lanes, plus three
// arithmetic stages and the output register.
// Reset clears all valid flags and the queue pointers and count.
// When the receiver stalls, the back pipeline freezes as a whole with its
// result held in the output register, the two-entry queue fills, and then
// the front and in_ready_o drop until the back moves again.
`default_nettype none
module bilinear_rgba_pixel_mix (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] pix_self_i,
  input  wire logic [31:0] pix_right_i,
  input  wire logic [31:0] pix_below_i,
  input  wire logic [31:0] pix_below_right_i,
  input  wire logic [15:0] frac_x_i,
  input  wire logic [15:0] frac_y_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      pixel_out_o
);

  logic                 push, full, pop, q_valid;
  bpm_pkg::front_item_t f_item, q_item;

  // Accept and classify items
  bpm_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .pix_self_i        (pix_self_i),
    .pix_right_i       (pix_right_i),
    .pix_below_i       (pix_below_i),
    .pix_below_right_i (pix_below_right_i),
    .frac_x_i          (frac_x_i),
    .frac_y_i          (frac_y_i),
    .push_o            (push),
    .item_o            (f_item),
    .full_i            (full)
  );

  // Decouple front and back
  bpm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  // Mix colors and drive the result
  bpm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .item_i      (q_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o)
  );

endmodule
`default_nettype wire
